// ===== src/axis_angle_to_rotation_matrix_core_macros.svh =====
// assertion macros for the axis-angle to rotation matrix core
// used by the port checker only, clock i_clk and reset i_rst_n are implied
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define AARM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aarm port check failed");

// next-cycle implication, off during reset
`define AARM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aarm port check failed");

// next-cycle implication that also holds through reset
`define AARM_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("aarm port check failed");

`endif

// ===== src/aarm_pkg.sv =====
// shared constants, types and rounding helper for the rotation matrix core
// no dependencies
package aarm_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int MOD_STEPS    = 6;
    localparam int DIV_LAT      = DIV_STEPS + 1;
    localparam int SC_LAT       = MOD_STEPS + 2 + CORDIC_STEPS;
    localparam int CORE_LAT     = (DIV_LAT > SC_LAT) ? DIV_LAT : SC_LAT;
    localparam int MAT_LAT      = 5;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LIM_W        = 25;

    localparam logic [59:0]        TWO_PI_Q52 = 60'h06487ED5110B461;
    localparam logic signed [33:0] ONE_Q30    = 34'sh040000000;
    localparam logic signed [33:0] PI_Q30     = 34'sh0C90FDAA2;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sh06487ED51;
    localparam logic signed [33:0] TWO_PI_Q30 = 34'sh1921FB544;
    localparam logic signed [33:0] GAIN_Q30   = 34'sh026DD3B6A;
    localparam logic signed [31:0] ONE_OUT    = 32'sh40000000;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // classified item handed from front to back
    typedef struct packed {
        logic signed [31:0] w_x;
        logic signed [31:0] w_y;
        logic signed [31:0] w_z;
        logic [31:0]        theta;
        logic               ident;
    } t_qent;

    // one finished matrix, row-major
    typedef struct packed {
        logic [8:0][31:0] ent;
        logic             ident;
    } t_res;

    // round q.60 product to q.30: add half, floor shift
    function automatic logic signed [37:0] rnd30(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = p + 68'sd536870912;
        return t[67:30];
    endfunction

endpackage

// ===== src/aarm_front.sv =====
// front end: input beat capture, squared norm, pipelined integer square root
// and small-angle classification; depends on aarm_pkg
module aarm_front import aarm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_w_x,
    input  logic signed [31:0] i_w_y,
    input  logic signed [31:0] i_w_z,
    input  logic [LIM_W-1:0]   i_limit,
    input  logic               i_q_full,
    output logic               o_push,
    output t_qent              o_entry
);

    logic en;

    logic               r_v0, r_v1, r_v2, r_vc;
    logic signed [31:0] r_w0 [3];
    logic signed [31:0] r_w1 [3];
    logic signed [31:0] r_w2 [3];
    logic [63:0]        r_sq1 [3];
    logic [63:0]        r_sum2;
    t_qent              r_ent;

    logic               r_sv   [SQRT_STEPS];
    logic [32:0]        r_rem  [SQRT_STEPS];
    logic [31:0]        r_root [SQRT_STEPS];
    logic [63:0]        r_n    [SQRT_STEPS];
    logic signed [31:0] r_sw   [SQRT_STEPS][3];

    // whole front holds only when the classified beat cannot enter the queue
    assign en      = !(r_vc && i_q_full);
    assign o_stall = !en;
    assign o_push  = r_vc && !i_q_full;
    assign o_entry = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vc <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_vc <= r_sv[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w0[0] <= i_w_x;
            r_w0[1] <= i_w_y;
            r_w0[2] <= i_w_z;
            for (int a = 0; a < 3; a++) begin
                r_sq1[a] <= 64'(64'(r_w0[a]) * 64'(r_w0[a]));
            end
            r_w1   <= r_w0;
            r_sum2 <= r_sq1[0] + r_sq1[1] + r_sq1[2];
            r_w2   <= r_w1;
            r_ent.w_x   <= r_sw[SQRT_STEPS-1][0];
            r_ent.w_y   <= r_sw[SQRT_STEPS-1][1];
            r_ent.w_z   <= r_sw[SQRT_STEPS-1][2];
            r_ent.theta <= r_root[SQRT_STEPS-1];
            r_ent.ident <= (r_root[SQRT_STEPS-1] <= {7'd0, i_limit});
        end
    end

    // one root bit per stage, two radicand bits per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic               v_in;
        logic [32:0]        rem_in;
        logic [31:0]        root_in;
        logic [63:0]        n_in;
        logic signed [31:0] w_in [3];
        logic [34:0]        rem_sh;
        logic [34:0]        trial;

        if (k == 0) begin : g_first
            assign v_in    = r_v2;
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = r_sum2;
            assign w_in    = r_w2;
        end else begin : g_next
            assign v_in    = r_sv[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign n_in    = r_n[k-1];
            assign w_in    = r_sw[k-1];
        end

        assign rem_sh = {rem_in, n_in[63:62]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (en) begin
                r_sv[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rem_sh >= trial) begin
                    r_rem[k]  <= 33'(rem_sh - trial);
                    r_root[k] <= {root_in[30:0], 1'b1};
                end else begin
                    r_rem[k]  <= rem_sh[32:0];
                    r_root[k] <= {root_in[30:0], 1'b0};
                end
                r_n[k]  <= {n_in[61:0], 2'b00};
                r_sw[k] <= w_in;
            end
        end
    end

endmodule

// ===== src/aarm_queue.sv =====
// short register queue between front and back
// depends on aarm_pkg
module aarm_queue import aarm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_entry,
    input  logic  i_pop,
    output t_qent o_entry,
    output logic  o_empty,
    output logic  o_full
);

    t_qent             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_entry = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== src/aarm_sincos.sv =====
// sine and cosine of the angle: modulo-2pi reduction, quadrant fold and
// pipelined rotation-mode cordic; depends on aarm_pkg
module aarm_sincos import aarm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_theta,
    output logic signed [33:0] o_sin,
    output logic signed [33:0] o_cos
);

    logic [59:0]        r_m [MOD_STEPS];
    logic signed [33:0] r_a1;
    logic signed [33:0] r_z0;
    logic               r_neg0;
    logic signed [33:0] r_x [CORDIC_STEPS];
    logic signed [33:0] r_y [CORDIC_STEPS];
    logic signed [33:0] r_z [CORDIC_STEPS];
    logic               r_ng [CORDIC_STEPS];

    logic signed [33:0] a0;

    // restoring reduction, quotient below 64
    for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
        localparam logic [59:0] SUB = TWO_PI_Q52 << (MOD_STEPS - 1 - j);
        logic [59:0] m_in;
        if (j == 0) begin : g_first
            assign m_in = {i_theta, 28'd0};
        end else begin : g_next
            assign m_in = r_m[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[j] <= (m_in >= SUB) ? m_in - SUB : m_in;
            end
        end
    end

    assign a0 = $signed({1'b0, r_m[MOD_STEPS-1][54:22]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1 <= (a0 > PI_Q30) ? a0 - TWO_PI_Q30 : a0;
            if (r_a1 > HALF_PI_Q30) begin
                r_z0   <= PI_Q30 - r_a1;
                r_neg0 <= 1'b1;
            end else if (r_a1 < -HALF_PI_Q30) begin
                r_z0   <= -PI_Q30 - r_a1;
                r_neg0 <= 1'b1;
            end else begin
                r_z0   <= r_a1;
                r_neg0 <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [33:0] x_in, y_in, z_in, dx, dy, at;
        logic               ng_in;
        if (i == 0) begin : g_first
            assign x_in  = GAIN_Q30;
            assign y_in  = '0;
            assign z_in  = r_z0;
            assign ng_in = r_neg0;
        end else begin : g_next
            assign x_in  = r_x[i-1];
            assign y_in  = r_y[i-1];
            assign z_in  = r_z[i-1];
            assign ng_in = r_ng[i-1];
        end
        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        assign at = $signed({2'b00, ATAN_Q30[i]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_in[33]) begin
                    r_x[i] <= x_in - dx;
                    r_y[i] <= y_in + dy;
                    r_z[i] <= z_in - at;
                end else begin
                    r_x[i] <= x_in + dx;
                    r_y[i] <= y_in - dy;
                    r_z[i] <= z_in + at;
                end
                r_ng[i] <= ng_in;
            end
        end
    end

    assign o_sin = r_y[CORDIC_STEPS-1];
    assign o_cos = r_ng[CORDIC_STEPS-1] ? -r_x[CORDIC_STEPS-1] : r_x[CORDIC_STEPS-1];

endmodule

// ===== src/aarm_back.sv =====
// back end: axis division, sine/cosine and the rodrigues matrix assembly
// depends on aarm_pkg and aarm_sincos
module aarm_back import aarm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_qent i_entry,
    input  logic  i_q_empty,
    output logic  o_pop,
    output logic  o_valid,
    output t_res  o_res
);

    localparam int PIPE_LEN = CORE_LAT + MAT_LAT;
    localparam int DLY_DIV  = CORE_LAT - DIV_LAT;
    localparam int DLY_SC   = CORE_LAT - SC_LAT;
    localparam int VT_SEL [9] = '{0, 3, 4, 3, 1, 5, 4, 5, 2};

    logic                r_b0v;
    t_qent               r_b0;
    logic [PIPE_LEN-1:0] r_vp;
    logic [PIPE_LEN-1:0] r_sp;

    logic [31:0]        mag [3];
    logic               sgn [3];
    logic [31:0]        r_dr  [3][DIV_STEPS];
    logic [30:0]        r_dq  [3][DIV_STEPS];
    logic               r_dsg [3][DIV_STEPS];
    logic [31:0]        r_dth [DIV_STEPS-1];
    logic signed [31:0] r_u   [3];

    logic signed [33:0] sin_w, cos_w;
    logic signed [31:0] u_c [3];
    logic signed [33:0] s_c, c_c;

    logic signed [63:0] r_uu [6];
    logic signed [65:0] r_su [3];
    logic signed [33:0] r_v1, r_v2;
    logic signed [33:0] r_k2r [6];
    logic signed [33:0] r_st2 [9];
    logic signed [33:0] r_st3 [9];
    logic signed [33:0] r_st4 [9];
    logic signed [67:0] r_vk [6];
    logic signed [33:0] r_vt [6];
    logic [31:0]        r_e [9];

    logic signed [35:0] esum [9];

    assign o_pop = i_en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0v <= 1'b0;
            r_vp  <= '0;
        end else if (i_en) begin
            r_b0v <= !i_q_empty;
            r_vp  <= {r_vp[PIPE_LEN-2:0], r_b0v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b0 <= i_entry;
            r_sp <= {r_sp[PIPE_LEN-2:0], r_b0.ident};
        end
    end

    assign sgn[0] = r_b0.w_x[31];
    assign sgn[1] = r_b0.w_y[31];
    assign sgn[2] = r_b0.w_z[31];
    assign mag[0] = sgn[0] ? 32'(-r_b0.w_x) : r_b0.w_x;
    assign mag[1] = sgn[1] ? 32'(-r_b0.w_y) : r_b0.w_y;
    assign mag[2] = sgn[2] ? 32'(-r_b0.w_z) : r_b0.w_z;

    // shared angle copy for the three dividers
    for (genvar j = 0; j < DIV_STEPS - 1; j++) begin : g_dth
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dth[j] <= (j == 0) ? r_b0.theta : r_dth[(j == 0) ? 0 : j-1];
            end
        end
    end

    // fractional restoring division, one quotient bit per stage
    for (genvar a = 0; a < 3; a++) begin : g_div
        for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
            logic [32:0] t;
            logic [31:0] th;
            logic [30:0] q_in;
            logic        sg_in;
            logic        ge;
            if (j == 0) begin : g_first
                assign t     = {1'b0, mag[a]};
                assign th    = r_b0.theta;
                assign q_in  = '0;
                assign sg_in = sgn[a];
            end else begin : g_next
                assign t     = {r_dr[a][j-1], 1'b0};
                assign th    = r_dth[j-1];
                assign q_in  = r_dq[a][j-1];
                assign sg_in = r_dsg[a][j-1];
            end
            assign ge = (t >= {1'b0, th});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dr[a][j]  <= ge ? 32'(t - {1'b0, th}) : t[31:0];
                    r_dq[a][j]  <= {q_in[29:0], ge};
                    r_dsg[a][j] <= sg_in;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_u[a] <= r_dsg[a][DIV_STEPS-1] ? -$signed({1'b0, r_dq[a][DIV_STEPS-1]})
                                                : $signed({1'b0, r_dq[a][DIV_STEPS-1]});
            end
        end
    end

    aarm_sincos u_sincos (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_theta (r_b0.theta),
        .o_sin   (sin_w),
        .o_cos   (cos_w)
    );

    // line up the two branches
    if (DLY_DIV > 0) begin : g_div_dly
        logic signed [31:0] r_ud [DLY_DIV][3];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ud[0] <= r_u;
                for (int d = 1; d < DLY_DIV; d++) begin
                    r_ud[d] <= r_ud[d-1];
                end
            end
        end
        assign u_c = r_ud[DLY_DIV-1];
    end else begin : g_div_now
        assign u_c = r_u;
    end

    if (DLY_SC > 0) begin : g_sc_dly
        logic signed [33:0] r_sd [DLY_SC];
        logic signed [33:0] r_cd [DLY_SC];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[0] <= sin_w;
                r_cd[0] <= cos_w;
                for (int d = 1; d < DLY_SC; d++) begin
                    r_sd[d] <= r_sd[d-1];
                    r_cd[d] <= r_cd[d-1];
                end
            end
        end
        assign s_c = r_sd[DLY_SC-1];
        assign c_c = r_cd[DLY_SC-1];
    end else begin : g_sc_now
        assign s_c = sin_w;
        assign c_c = cos_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // axis products and sine products
            r_uu[0] <= 64'(u_c[0]) * 64'(u_c[0]);
            r_uu[1] <= 64'(u_c[1]) * 64'(u_c[1]);
            r_uu[2] <= 64'(u_c[2]) * 64'(u_c[2]);
            r_uu[3] <= 64'(u_c[0]) * 64'(u_c[1]);
            r_uu[4] <= 64'(u_c[0]) * 64'(u_c[2]);
            r_uu[5] <= 64'(u_c[1]) * 64'(u_c[2]);
            for (int a = 0; a < 3; a++) begin
                r_su[a] <= 66'(s_c) * 66'(u_c[a]);
            end
            r_v1 <= ONE_Q30 - c_c;

            // rounded k squared and sine terms
            r_k2r[0] <= 34'(rnd30(-68'(r_uu[1] + r_uu[2])));
            r_k2r[1] <= 34'(rnd30(-68'(r_uu[0] + r_uu[2])));
            r_k2r[2] <= 34'(rnd30(-68'(r_uu[0] + r_uu[1])));
            r_k2r[3] <= 34'(rnd30(68'(r_uu[3])));
            r_k2r[4] <= 34'(rnd30(68'(r_uu[4])));
            r_k2r[5] <= 34'(rnd30(68'(r_uu[5])));
            r_st2[0] <= '0;
            r_st2[4] <= '0;
            r_st2[8] <= '0;
            r_st2[1] <= 34'(rnd30(-68'(r_su[2])));
            r_st2[2] <= 34'(rnd30(68'(r_su[1])));
            r_st2[3] <= 34'(rnd30(68'(r_su[2])));
            r_st2[5] <= 34'(rnd30(-68'(r_su[0])));
            r_st2[6] <= 34'(rnd30(-68'(r_su[1])));
            r_st2[7] <= 34'(rnd30(68'(r_su[0])));
            r_v2 <= r_v1;

            for (int i = 0; i < 6; i++) begin
                r_vk[i] <= 68'(r_v2) * 68'(r_k2r[i]);
            end
            r_st3 <= r_st2;

            for (int i = 0; i < 6; i++) begin
                r_vt[i] <= 34'(rnd30(r_vk[i]));
            end
            r_st4 <= r_st3;

            for (int i = 0; i < 9; i++) begin
                if (esum[i] > 36'sh07FFFFFFF) begin
                    r_e[i] <= 32'h7FFFFFFF;
                end else if (esum[i] < -36'sh080000000) begin
                    r_e[i] <= 32'h80000000;
                end else begin
                    r_e[i] <= esum[i][31:0];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            esum[i] = 36'(r_st4[i]) + 36'(r_vt[VT_SEL[i]]);
            if (i == 0 || i == 4 || i == 8) begin
                esum[i] = esum[i] + 36'(ONE_Q30);
            end
        end
    end

    assign o_valid = r_vp[PIPE_LEN-1];
    always_comb begin
        o_res.ident = r_sp[PIPE_LEN-1];
        for (int i = 0; i < 9; i++) begin
            if (r_sp[PIPE_LEN-1]) begin
                o_res.ent[i] = (i == 0 || i == 4 || i == 8) ? ONE_OUT : '0;
            end else begin
                o_res.ent[i] = r_e[i];
            end
        end
    end

endmodule

// ===== src/axis_angle_to_rotation_matrix_core.sv =====
// top level of the rotation vector to rotation matrix core (rodrigues formula)
// depends on aarm_pkg, aarm_front, aarm_queue, aarm_back
//
//  channel   direction  handshake                   payload
//  in        to core    i_in_valid / o_in_stall     i_omega_x, i_omega_y, i_omega_z
//  out       from core  o_out_valid / i_out_stall   o_r00 .. o_r22, o_small_angle
//  cfg       to core    i_cfg_we                    i_cfg_wdata (small-angle limit)
//
// one beat per cycle in and out when nothing stalls
// path from the accepting edge to the result on the port: front capture, squared norm, square root
//   and classification, the queue, the divider and sine/cosine branches, the matrix stages and one
//   output register
// reset: synchronous active low, clears valids, queue pointers and the limit register
// a stall on the out side fills the output register and one skid beat, then freezes the
//   back; the queue then fills and the front raises o_in_stall
module axis_angle_to_rotation_matrix_core import aarm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_omega_x,
    input  logic signed [31:0] i_omega_y,
    input  logic signed [31:0] i_omega_z,
    input  logic               i_cfg_we,
    input  logic [LIM_W-1:0]   i_cfg_wdata,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_r00,
    output logic signed [31:0] o_r01,
    output logic signed [31:0] o_r02,
    output logic signed [31:0] o_r10,
    output logic signed [31:0] o_r11,
    output logic signed [31:0] o_r12,
    output logic signed [31:0] o_r20,
    output logic signed [31:0] o_r21,
    output logic signed [31:0] o_r22,
    output logic               o_small_angle
);

    // small-angle threshold; write only while the core is idle, the core itself does not enforce this
    logic [LIM_W-1:0] r_limit;

    // front to queue
    logic  push;
    t_qent f_entry;
    logic  q_full;

    // queue to back
    t_qent q_entry;
    logic  q_empty;
    logic  pop;

    // back to output stage
    logic en_b;
    logic b_valid;
    t_res b_res;

    // output register plus one skid beat
    logic r_ov, r_hv;
    t_res r_out, r_hold;
    logic out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    aarm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_w_x    (i_omega_x),
        .i_w_y    (i_omega_y),
        .i_w_z    (i_omega_z),
        .i_limit  (r_limit),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (f_entry)
    );

    aarm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // the back only moves while the skid slot is free, a registered condition
    assign en_b = !r_hv;

    aarm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en_b),
        .i_entry   (q_entry),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_valid   (b_valid),
        .o_res     (b_res)
    );

    assign out_take = r_ov && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_hv <= 1'b0;
        end else if (r_hv) begin
            // back frozen, skid beat moves up once the output is taken
            if (out_take) begin
                r_hv <= 1'b0;
            end
        end else if (b_valid) begin
            if (!r_ov || out_take) begin
                r_ov <= 1'b1;
            end else begin
                r_hv <= 1'b1;
            end
        end else if (out_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_hv) begin
            if (out_take) begin
                r_out <= r_hold;
            end
        end else if (b_valid) begin
            if (!r_ov || out_take) begin
                r_out <= b_res;
            end else begin
                r_hold <= b_res;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_r00         = r_out.ent[0];
    assign o_r01         = r_out.ent[1];
    assign o_r02         = r_out.ent[2];
    assign o_r10         = r_out.ent[3];
    assign o_r11         = r_out.ent[4];
    assign o_r12         = r_out.ent[5];
    assign o_r20         = r_out.ent[6];
    assign o_r21         = r_out.ent[7];
    assign o_r22         = r_out.ent[8];
    assign o_small_angle = r_out.ident;

endmodule

// ===== src/aarm_checker.sv =====
// port checker for the rotation matrix core, bound to the top level
// depends on aarm_pkg and the assertion macro header
`include "axis_angle_to_rotation_matrix_core_macros.svh"

module aarm_checker import aarm_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic signed [31:0] i_omega_x,
    input logic signed [31:0] i_omega_y,
    input logic signed [31:0] i_omega_z,
    input logic               i_cfg_we,
    input logic [LIM_W-1:0]   i_cfg_wdata,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_r00,
    input logic signed [31:0] o_r01,
    input logic signed [31:0] o_r02,
    input logic signed [31:0] o_r10,
    input logic signed [31:0] o_r11,
    input logic signed [31:0] o_r12,
    input logic signed [31:0] o_r20,
    input logic signed [31:0] o_r21,
    input logic signed [31:0] o_r22,
    input logic               o_small_angle
);

    // a stalled result beat stays
    `AARM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // flagged beats carry the exact identity
    `AARM_ASSERT_NOW(a_small_ident, o_out_valid && o_small_angle, o_r00 == ONE_OUT && o_r11 == ONE_OUT && o_r22 == ONE_OUT && o_r01 == 32'sd0 && o_r02 == 32'sd0 && o_r10 == 32'sd0 && o_r12 == 32'sd0 && o_r20 == 32'sd0 && o_r21 == 32'sd0)

    // a stalled result beat keeps its payload until it is taken, checked on a sample of the entries
    `AARM_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_r00) && $stable(o_r12) && $stable(o_r21) && $stable(o_small_angle))

    // reset leaves no result and an open input
    `AARM_ASSERT_ALWAYS(a_reset_clear, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind axis_angle_to_rotation_matrix_core aarm_checker u_aarm_checker (.*);
